### rtl/core/ebal_pkg.sv
// Package for the extent bump allocator: request codes, adder operation codes,
// default sizes and the structs that pass between the sequencer and the top level.
// Depends on nothing.
package ebal_pkg;

  localparam int BATCH_COUNT_DEF = 8;
  localparam int ADDR_BITS_DEF = 48;

  localparam logic [4:0] EXT_LOG2_RST = 5'd17;
  localparam logic [4:0] EXT_LOG2_MIN = 5'd12;
  localparam logic [4:0] EXT_LOG2_MAX = 5'd30;

  localparam int KIND_SHIFT = 8;
  localparam int EXTNUM_SHIFT = 16;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_ATTACH = 2'd1;
  localparam logic [1:0] REQ_PRIME = 2'd2;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  batch;
    logic [30:0] byte_count;
    logic [4:0]  align_log2;
    logic        boundary_on;
    logic [4:0]  boundary_log2;
    logic [47:0] fresh_extent;
    logic        fresh_ok;
    logic [47:0] attach_addr;
    logic [7:0]  page_kind;
  } ebal_req_t;

  typedef struct packed {
    logic        status;
    logic [47:0] addr_first;
    logic [47:0] addr_second;
    logic [47:0] spare_out;
    logic        record_valid;
    logic [63:0] record_word;
    logic [47:0] next_hint;
  } ebal_res_t;

  typedef struct packed {
    logic       nf_we;
    logic       sp_we;
    logic       kd_we;
    logic [7:0] idx;
  } ebal_wr_t;

endpackage

### rtl/core/ebal_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module ebal_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/ebal_alu.sv
// Shared adder of the allocator: one add or subtract with carry out, used for
// every alignment, boundary, room and piece step. Depends on ebal_pkg.
module ebal_alu import ebal_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 op,
  input  logic [ADDR_BITS-1:0] a,
  input  logic [ADDR_BITS-1:0] b,
  output logic [ADDR_BITS-1:0] y,
  output logic                 co
);

  logic [ADDR_BITS-1:0] b_eff;
  logic [ADDR_BITS:0]   sum;

  assign b_eff = (op == ALU_SUB) ? ~b : b;
  assign sum = {1'b0, a} + {1'b0, b_eff} + {{ADDR_BITS{1'b0}}, op};
  assign y = sum[ADDR_BITS-1:0];
  assign co = sum[ADDR_BITS];

endmodule

### rtl/core/ebal_seq.sv
// Sequencer of the allocator: holds one transaction, steps it through the
// shared adder and produces the state writes and the result.
// Depends on ebal_pkg and ebal_alu.
module ebal_seq import ebal_pkg::*; #(
  parameter int BATCH_COUNT = BATCH_COUNT_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ebal_req_t            req,
  input  logic [4:0]           el,
  input  logic [ADDR_BITS-1:0] nf_q,
  input  logic [ADDR_BITS-1:0] sp_q,
  input  logic [7:0]           kd_q,
  input  logic                 nf_ok,
  input  logic                 kd_ok,
  input  logic                 out_free,
  output logic                 busy,
  output logic                 done,
  output ebal_wr_t             wr,
  output logic [ADDR_BITS-1:0] nf_wd,
  output logic [ADDR_BITS-1:0] sp_wd,
  output logic [7:0]           kd_wd,
  output ebal_res_t            res
);

  localparam int AW = ADDR_BITS;
  localparam logic [AW-1:0] ONES = '1;
  localparam logic [AW-1:0] ONE = {{(AW-1){1'b0}}, 1'b1};

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_SAT   = 4'd2;
  localparam logic [3:0] S_ALIGN = 4'd3;
  localparam logic [3:0] S_BCHK1 = 4'd4;
  localparam logic [3:0] S_BCHK2 = 4'd5;
  localparam logic [3:0] S_BCHK3 = 4'd6;
  localparam logic [3:0] S_BCHK4 = 4'd7;
  localparam logic [3:0] S_PTEST = 4'd8;
  localparam logic [3:0] S_ROOM  = 4'd9;
  localparam logic [3:0] S_CMP   = 4'd10;
  localparam logic [3:0] S_SUBN  = 4'd11;
  localparam logic [3:0] S_ADV   = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  logic [3:0]    state;
  ebal_req_t     req_r;
  logic [30:0]   n_r;
  logic [AW-1:0] nxt;
  logic [AW-1:0] spare;
  logic [7:0]    kind;
  logic [AW-1:0] tmp;
  logic          k;
  logic          st;
  logic [AW-1:0] a0;
  logic [AW-1:0] a1;
  logic          rv;
  logic [63:0]   rw;
  logic          oor;

  logic          alu_op;
  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic [AW-1:0] alu_y;
  logic          alu_co;

  logic [AW-1:0] esz;
  logic [AW-1:0] emask;
  logic [AW-1:0] almask;
  logic [AW-1:0] bsm;
  logic [AW-1:0] bs;
  logic [AW-1:0] n_ext;
  logic [AW-1:0] off_e;
  logic [AW-1:0] fresh_e;
  logic [AW-1:0] att_e;
  logic [7:0]    kind_ld;
  logic          oor_c;
  logic [AW-1:0] hint;

  function automatic logic [63:0] pack_rec(input logic [AW-1:0] addr, input logic [7:0] kd,
                                           input logic [2:0] bt, input logic [4:0] sh);
    logic [63:0] t;
    t = 64'(addr) >> sh;
    return {t[63-EXTNUM_SHIFT:0], kd, 5'd0, bt};
  endfunction

  assign esz = ONE << el;
  assign emask = ~(ONES << el);
  assign almask = ~(ONES << req_r.align_log2);
  assign bsm = ~(ONES << req_r.boundary_log2);
  assign bs = ONE << req_r.boundary_log2;
  assign n_ext = AW'(n_r);
  assign off_e = nxt & emask;
  assign fresh_e = AW'(req_r.fresh_extent);
  assign att_e = AW'(req_r.attach_addr);
  assign kind_ld = kd_ok ? kd_q : 8'd0;
  assign oor_c = {29'd0, req_r.batch} >= 32'(BATCH_COUNT);
  assign hint = (off_e != '0) ? nxt : spare;

  always_comb begin
    alu_op = ALU_ADD;
    alu_a = '0;
    alu_b = '0;
    case (state)
      S_SAT: begin
        alu_op = ALU_SUB;
        alu_a = esz;
        alu_b = n_ext;
      end
      S_ALIGN: begin
        alu_a = nxt;
        alu_b = almask;
      end
      S_BCHK1: begin
        alu_op = ALU_SUB;
        alu_a = bs;
        alu_b = n_ext;
      end
      S_BCHK2: begin
        alu_a = nxt & bsm;
        alu_b = n_ext;
      end
      S_BCHK3: begin
        alu_op = ALU_SUB;
        alu_a = bs;
        alu_b = tmp;
      end
      S_BCHK4: begin
        alu_a = nxt | bsm;
        alu_b = ONE;
      end
      S_ROOM: begin
        alu_op = ALU_SUB;
        alu_a = esz;
        alu_b = off_e;
      end
      S_CMP, S_SUBN: begin
        alu_op = ALU_SUB;
        alu_a = n_ext;
        alu_b = tmp;
      end
      S_ADV: begin
        alu_a = nxt;
        alu_b = tmp;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  ebal_alu #(
    .ADDR_BITS(ADDR_BITS)
  ) u_alu (
    .op(alu_op),
    .a(alu_a),
    .b(alu_b),
    .y(alu_y),
    .co(alu_co)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            req_r <= req;
            st <= 1'b0;
            a0 <= '0;
            a1 <= '0;
            rv <= 1'b0;
            rw <= '0;
            k <= 1'b0;
            oor <= 1'b0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          nxt <= nf_ok ? nf_q : '0;
          spare <= (req_r.req_type == REQ_PRIME) ? fresh_e : sp_q;
          kind <= (req_r.req_type == REQ_PRIME) ? req_r.page_kind : kind_ld;
          n_r <= req_r.byte_count;
          if (oor_c) begin
            oor <= 1'b1;
            state <= S_FIN;
          end else begin
            case (req_r.req_type)
              REQ_ALLOC: begin
                state <= S_SAT;
              end
              REQ_ATTACH: begin
                rv <= 1'b1;
                rw <= pack_rec(att_e, kind_ld, req_r.batch, el);
                state <= S_FIN;
              end
              REQ_PRIME: begin
                state <= S_FIN;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_SAT: begin
          if (!alu_co) begin
            n_r <= esz[30:0];
          end
          state <= S_ALIGN;
        end
        S_ALIGN: begin
          nxt <= alu_y & ~almask;
          state <= (req_r.boundary_on && n_r != '0) ? S_BCHK1 : S_PTEST;
        end
        S_BCHK1: begin
          state <= alu_co ? S_BCHK2 : S_PTEST;
        end
        S_BCHK2: begin
          tmp <= alu_y;
          state <= S_BCHK3;
        end
        S_BCHK3: begin
          state <= alu_co ? S_PTEST : S_BCHK4;
        end
        S_BCHK4: begin
          nxt <= alu_y;
          state <= S_PTEST;
        end
        S_PTEST: begin
          if (n_r == '0) begin
            state <= S_FIN;
          end else if (off_e == '0) begin
            if (!req_r.fresh_ok) begin
              st <= 1'b1;
              state <= S_FIN;
            end else begin
              spare <= fresh_e;
              nxt <= spare & ~emask;
              rv <= 1'b1;
              rw <= pack_rec(spare, kind, req_r.batch, el);
              state <= S_ROOM;
            end
          end else begin
            state <= S_ROOM;
          end
        end
        S_ROOM: begin
          tmp <= alu_y;
          state <= S_CMP;
        end
        S_CMP: begin
          if (!alu_co) begin
            tmp <= n_ext;
          end
          if (k) begin
            a1 <= nxt;
          end else begin
            a0 <= nxt;
          end
          state <= S_SUBN;
        end
        S_SUBN: begin
          n_r <= alu_y[30:0];
          state <= S_ADV;
        end
        S_ADV: begin
          nxt <= alu_y;
          k <= 1'b1;
          state <= k ? S_FIN : S_PTEST;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_FIN) && out_free;

  always_comb begin
    wr.nf_we = (state == S_FIN) && !oor && (req_r.req_type == REQ_ALLOC);
    wr.sp_we = (state == S_FIN) && !oor &&
               ((req_r.req_type == REQ_ALLOC) || (req_r.req_type == REQ_PRIME));
    wr.kd_we = (state == S_FIN) && !oor && (req_r.req_type == REQ_PRIME);
    wr.idx = {5'd0, req_r.batch};
  end

  assign nf_wd = nxt;
  assign sp_wd = spare;
  assign kd_wd = kind;

  always_comb begin
    if (oor) begin
      res = '0;
    end else begin
      res.status = st;
      res.addr_first = 48'(a0);
      res.addr_second = 48'(a1);
      res.spare_out = 48'(spare);
      res.record_valid = rv;
      res.record_word = rw;
      res.next_hint = 48'(hint);
    end
  end

endmodule

### rtl/core/extent_bump_allocator_unit.sv
// Top level of the extent bump allocator: configuration register, per-batch
// state memories with valid bits, sequencer and result register.
// Depends on ebal_pkg, ebal_ram and ebal_seq.
//
// Usage: a request transaction is accepted when in_valid is high and in_stall
// is low; a result transaction is taken when out_valid is high and out_stall
// is low. Every request yields exactly one result, in order.
// The block works on one request at a time; in_stall is high from the cycle
// after acceptance until the request has been handed to the result register.
// All arithmetic runs through one shared adder, one step per cycle. Attach,
// prime and unused requests take no adder steps; an allocate takes saturation,
// alignment, up to four boundary steps and five steps for each of at most two
// pieces. The result is registered when the sequencer finishes and appears in
// the cycle after it, when the next request may also be accepted.
// The result register holds a finished result while the receiver stalls; a
// following request is still accepted and worked on, and it waits at its end
// until the register is free.
// Reset clears next_free and page kind of every batch through valid bits, sets
// extent_size_log2 to 17 and needs no clearing pass. cfg_we writes the extent
// size register; the user, not the block, ensures no request is in progress.
module extent_bump_allocator_unit import ebal_pkg::*; #(
  parameter int BATCH_COUNT = BATCH_COUNT_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [2:0]  batch,
  input  logic [30:0] byte_count,
  input  logic [4:0]  align_log2,
  input  logic        boundary_on,
  input  logic [4:0]  boundary_log2,
  input  logic [47:0] fresh_extent,
  input  logic        fresh_ok,
  input  logic [47:0] attach_addr,
  input  logic [7:0]  page_kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [47:0] addr_first,
  output logic [47:0] addr_second,
  output logic [47:0] spare_out,
  output logic        record_valid,
  output logic [63:0] record_word,
  output logic [47:0] next_hint
);

  localparam int BW = (BATCH_COUNT > 1) ? $clog2(BATCH_COUNT) : 1;

  logic [4:0]           extent_size_log2;
  logic [4:0]           el;
  ebal_req_t            req;
  logic                 start;
  logic                 busy;
  logic                 done;
  logic                 out_free;
  ebal_wr_t             wr;
  ebal_res_t            res;
  ebal_res_t            res_q;
  logic [ADDR_BITS-1:0] nf_q;
  logic [ADDR_BITS-1:0] sp_q;
  logic [7:0]           kd_q;
  logic [ADDR_BITS-1:0] nf_wd;
  logic [ADDR_BITS-1:0] sp_wd;
  logic [7:0]           kd_wd;
  logic [BATCH_COUNT-1:0] nf_vld;
  logic [BATCH_COUNT-1:0] kd_vld;
  logic                 nf_ok;
  logic                 kd_ok;
  logic [7:0]           rbatch;
  logic [BW-1:0]        ridx;
  logic [BW-1:0]        widx;

  always_ff @(posedge clk) begin
    if (rst) begin
      extent_size_log2 <= EXT_LOG2_RST;
    end else if (cfg_we) begin
      extent_size_log2 <= cfg_wdata;
    end
  end

  always_comb begin
    if (extent_size_log2 < EXT_LOG2_MIN) begin
      el = EXT_LOG2_MIN;
    end else if (extent_size_log2 > EXT_LOG2_MAX) begin
      el = EXT_LOG2_MAX;
    end else begin
      el = extent_size_log2;
    end
  end

  always_comb begin
    req.req_type = req_type;
    req.batch = batch;
    req.byte_count = byte_count;
    req.align_log2 = align_log2;
    req.boundary_on = boundary_on;
    req.boundary_log2 = boundary_log2;
    req.fresh_extent = fresh_extent;
    req.fresh_ok = fresh_ok;
    req.attach_addr = attach_addr;
    req.page_kind = page_kind;
  end

  assign in_stall = busy;
  assign start = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign rbatch = {5'd0, batch};
  assign ridx = rbatch[BW-1:0];
  assign widx = wr.idx[BW-1:0];

  ebal_ram #(
    .WIDTH(ADDR_BITS),
    .DEPTH(BATCH_COUNT)
  ) u_nf_ram (
    .clk(clk),
    .we(wr.nf_we),
    .waddr(widx),
    .wdata(nf_wd),
    .raddr(ridx),
    .rdata(nf_q)
  );

  ebal_ram #(
    .WIDTH(ADDR_BITS),
    .DEPTH(BATCH_COUNT)
  ) u_sp_ram (
    .clk(clk),
    .we(wr.sp_we),
    .waddr(widx),
    .wdata(sp_wd),
    .raddr(ridx),
    .rdata(sp_q)
  );

  ebal_ram #(
    .WIDTH(8),
    .DEPTH(BATCH_COUNT)
  ) u_kd_ram (
    .clk(clk),
    .we(wr.kd_we),
    .waddr(widx),
    .wdata(kd_wd),
    .raddr(ridx),
    .rdata(kd_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      nf_vld <= '0;
      kd_vld <= '0;
    end else begin
      if (wr.nf_we) begin
        nf_vld[widx] <= 1'b1;
      end
      if (wr.kd_we) begin
        kd_vld[widx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    nf_ok <= nf_vld[ridx];
    kd_ok <= kd_vld[ridx];
  end

  ebal_seq #(
    .BATCH_COUNT(BATCH_COUNT),
    .ADDR_BITS(ADDR_BITS)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .start(start),
    .req(req),
    .el(el),
    .nf_q(nf_q),
    .sp_q(sp_q),
    .kd_q(kd_q),
    .nf_ok(nf_ok),
    .kd_ok(kd_ok),
    .out_free(out_free),
    .busy(busy),
    .done(done),
    .wr(wr),
    .nf_wd(nf_wd),
    .sp_wd(sp_wd),
    .kd_wd(kd_wd),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_q <= res;
    end
  end

  assign status = res_q.status;
  assign addr_first = res_q.addr_first;
  assign addr_second = res_q.addr_second;
  assign spare_out = res_q.spare_out;
  assign record_valid = res_q.record_valid;
  assign record_word = res_q.record_word;
  assign next_hint = res_q.next_hint;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("Request accepted while the sequencer did not become busy.");

  a_fail_no_second: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (addr_second == '0))
    else $error("Failed allocation reports a second piece.");

  a_split_has_record: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (addr_second != '0)) |-> record_valid)
    else $error("Split allocation without an extent record.");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !(wr.nf_we || wr.sp_we || wr.kd_we))
    else $error("State memory written while no request is in progress.");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for extent_bump_allocator_unit: directed corner cases and random
// allocate, attach and prime traffic, checked against an in-bench allocator predictor.
// Depends on ebal_pkg and the extent_bump_allocator_unit RTL.
module testbench import ebal_pkg::*; ();

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [63:0] ADDR_MASK = 64'h0000_FFFF_FFFF_FFFF;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [2:0]  batch = '0;
  logic [30:0] byte_count = '0;
  logic [4:0]  align_log2 = '0;
  logic        boundary_on = 1'b0;
  logic [4:0]  boundary_log2 = '0;
  logic [47:0] fresh_extent = '0;
  logic        fresh_ok = 1'b0;
  logic [47:0] attach_addr = '0;
  logic [7:0]  page_kind = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        status;
  logic [47:0] addr_first;
  logic [47:0] addr_second;
  logic [47:0] spare_out;
  logic        record_valid;
  logic [63:0] record_word;
  logic [47:0] next_hint;

  logic [47:0] free_ptr [8];
  logic [47:0] spare_ext [8];
  logic [7:0]  kind_of [8];
  logic [4:0]  ext_log2_reg;

  ebal_res_t   awaited[$];
  int          mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int          hold_left = 0;
  int          cycles = 0;

  extent_bump_allocator_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .batch(batch),
    .byte_count(byte_count),
    .align_log2(align_log2),
    .boundary_on(boundary_on),
    .boundary_log2(boundary_log2),
    .fresh_extent(fresh_extent),
    .fresh_ok(fresh_ok),
    .attach_addr(attach_addr),
    .page_kind(page_kind),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .addr_first(addr_first),
    .addr_second(addr_second),
    .spare_out(spare_out),
    .record_valid(record_valid),
    .record_word(record_word),
    .next_hint(next_hint)
  );

  always #10 clk = ~clk;

  function automatic int extent_log2_now();
    int el;
    el = int'(ext_log2_reg);
    if (el < 12) el = 12;
    if (el > 30) el = 30;
    return el;
  endfunction

  function automatic logic [63:0] record_of(input logic [63:0] addr, input logic [7:0] kind,
                                            input logic [2:0] b, input int el);
    return (((addr & ADDR_MASK) >> el) << EXTNUM_SHIFT) | ({56'd0, kind} << KIND_SHIFT) |
           {61'd0, b};
  endfunction

  function automatic ebal_res_t allocator_response(input ebal_req_t r);
    ebal_res_t   res;
    logic [63:0] esz, emask, n, al, nxt, bs, ext, room, piece, hint_base;
    logic [63:0] pieces [2];
    logic [2:0]  b;
    int          el, bl;
    bit          halted;
    res = '0;
    b = r.batch;
    el = extent_log2_now();
    esz = 64'd1 << el;
    emask = esz - 64'd1;
    pieces[0] = '0;
    pieces[1] = '0;
    case (r.req_type)
      REQ_ALLOC: begin
        n = {33'd0, r.byte_count};
        if (n > esz) n = esz;
        al = 64'd1 << r.align_log2;
        nxt = ({16'd0, free_ptr[b]} + al - 64'd1) & ~(al - 64'd1) & ADDR_MASK;
        if (r.boundary_on && n != 0) begin
          bl = int'(r.boundary_log2);
          bs = 64'd1 << bl;
          if (n <= bs && (nxt >> bl) != (((nxt + n - 64'd1) & ADDR_MASK) >> bl))
            nxt = ((nxt | (bs - 64'd1)) + 64'd1) & ADDR_MASK;
        end
        halted = 1'b0;
        for (int k = 0; k < 2; k++) begin
          if (n != 0 && !halted) begin
            if ((nxt & emask) == 0) begin
              if (!r.fresh_ok) begin
                res.status = 1'b1;
                halted = 1'b1;
              end else begin
                ext = {16'd0, spare_ext[b]};
                spare_ext[b] = r.fresh_extent;
                nxt = ext & ~emask;
                res.record_valid = 1'b1;
                res.record_word = record_of(ext, kind_of[b], b, el);
              end
            end
            if (!halted) begin
              room = esz - (nxt & emask);
              piece = (n < room) ? n : room;
              pieces[k] = nxt;
              n = n - piece;
              nxt = (nxt + piece) & ADDR_MASK;
            end
          end
        end
        free_ptr[b] = nxt[47:0];
        res.addr_first = pieces[0][47:0];
        res.addr_second = pieces[1][47:0];
      end
      REQ_ATTACH: begin
        res.record_valid = 1'b1;
        res.record_word = record_of({16'd0, r.attach_addr}, kind_of[b], b, el);
      end
      REQ_PRIME: begin
        spare_ext[b] = r.fresh_extent;
        kind_of[b] = r.page_kind;
      end
      default: ;
    endcase
    hint_base = {16'd0, free_ptr[b]};
    res.spare_out = spare_ext[b];
    res.next_hint = ((hint_base & emask) != 0) ? free_ptr[b] : spare_ext[b];
    return res;
  endfunction

  function automatic ebal_req_t make_alloc(input logic [2:0] b, input logic [30:0] n,
                                           input logic [4:0] al, input logic bon,
                                           input logic [4:0] bl, input logic [47:0] fresh,
                                           input logic ok);
    ebal_req_t r;
    r = '0;
    r.req_type = REQ_ALLOC;
    r.batch = b;
    r.byte_count = n;
    r.align_log2 = al;
    r.boundary_on = bon;
    r.boundary_log2 = bl;
    r.fresh_extent = fresh;
    r.fresh_ok = ok;
    return r;
  endfunction

  function automatic ebal_req_t make_attach(input logic [2:0] b, input logic [47:0] addr);
    ebal_req_t r;
    r = '0;
    r.req_type = REQ_ATTACH;
    r.batch = b;
    r.attach_addr = addr;
    return r;
  endfunction

  function automatic ebal_req_t random_request();
    ebal_req_t   r;
    int          el;
    int unsigned esz, pick;
    logic [47:0] ext_mask;
    el = extent_log2_now();
    esz = 32'd1 << el;
    ext_mask = ~((48'd1 << el) - 48'd1);
    r.batch = 3'($urandom_range(7));
    case ($urandom_range(9))
      0: r.byte_count = '0;
      1, 2, 3: r.byte_count = 31'($urandom_range(64, 1));
      4, 5: r.byte_count = 31'($urandom_range(esz / 16, 1));
      6: r.byte_count = 31'(esz - $urandom_range(16));
      7: r.byte_count = 31'(esz + $urandom_range(16));
      8: r.byte_count = 31'($urandom());
      default: r.byte_count = 31'($urandom_range(esz, 1));
    endcase
    pick = $urandom_range(9);
    if (pick < 7) r.align_log2 = 5'($urandom_range(4));
    else if (pick < 9) r.align_log2 = 5'($urandom_range(12));
    else r.align_log2 = 5'($urandom_range(31));
    r.boundary_on = ($urandom_range(99) < 30);
    r.boundary_log2 = ($urandom_range(1) == 0) ? 5'($urandom_range(14, 4)) :
                                                 5'($urandom_range(31));
    r.fresh_extent = {16'($urandom()), $urandom()};
    if ($urandom_range(4) != 0) r.fresh_extent = r.fresh_extent & ext_mask;
    r.fresh_ok = ($urandom_range(9) != 0);
    r.attach_addr = {16'($urandom()), $urandom()};
    r.page_kind = 8'($urandom());
    pick = $urandom_range(99);
    if (pick < 75) r.req_type = REQ_ALLOC;
    else if (pick < 85) r.req_type = REQ_ATTACH;
    else if (pick < 95) r.req_type = REQ_PRIME;
    else r.req_type = REQ_UNUSED;
    return r;
  endfunction

  task automatic send_req(input ebal_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r.req_type;
    batch <= r.batch;
    byte_count <= r.byte_count;
    align_log2 <= r.align_log2;
    boundary_on <= r.boundary_on;
    boundary_log2 <= r.boundary_log2;
    fresh_extent <= r.fresh_extent;
    fresh_ok <= r.fresh_ok;
    attach_addr <= r.attach_addr;
    page_kind <= r.page_kind;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited.push_back(allocator_response(r));
  endtask

  task automatic set_extent_log2(input logic [4:0] value);
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ext_log2_reg = value;
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  always @(posedge clk) begin
    ebal_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        report_mismatch("result transaction with no request outstanding");
      end else begin
        want = awaited.pop_front();
        check_field("status", 64'(status), 64'(want.status));
        check_field("addr_first", 64'(addr_first), 64'(want.addr_first));
        check_field("addr_second", 64'(addr_second), 64'(want.addr_second));
        check_field("spare_out", 64'(spare_out), 64'(want.spare_out));
        check_field("record_valid", 64'(record_valid), 64'(want.record_valid));
        check_field("record_word", record_word, want.record_word);
        check_field("next_hint", 64'(next_hint), 64'(want.next_hint));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic test_prime_batches();
    ebal_req_t r;
    for (int b = 0; b < 8; b++) begin
      r = '0;
      r.req_type = REQ_PRIME;
      r.batch = 3'(b);
      r.page_kind = (b == 7) ? 8'hFF : 8'(b * 37);
      if (b == 7) r.fresh_extent = 48'hFFFF_FFFE_0000;
      else if (b == 6) r.fresh_extent = 48'h0000_0700_1234;
      else r.fresh_extent = 48'(b + 1) << 24;
      send_req(r);
    end
  endtask

  task automatic test_corner_cases();
    ebal_req_t r;
    send_req(make_alloc(3'd0, 31'd0, 5'd3, 1'b1, 5'd0, 48'h0, 1'b1));
    send_req(make_alloc(3'd0, 31'd100, 5'd0, 1'b0, 5'd0, 48'h0000_0A00_0000, 1'b1));
    send_req(make_alloc(3'd0, 31'd64, 5'd6, 1'b0, 5'd0, 48'h0, 1'b1));
    send_req(make_alloc(3'd0, 31'd256, 5'd0, 1'b1, 5'd8, 48'h0, 1'b1));
    send_req(make_alloc(3'd0, 31'h7FFF_FFFF, 5'd0, 1'b0, 5'd0, 48'h0000_0B00_0000, 1'b1));
    send_req(make_alloc(3'd0, 31'd131072, 5'd0, 1'b0, 5'd0, 48'h0, 1'b0));
    send_req(make_alloc(3'd1, 31'd10, 5'd0, 1'b0, 5'd0, 48'h0, 1'b0));
    send_req(make_attach(3'd2, 48'hFFFF_FFFF_FFFF));
    send_req(make_attach(3'd3, 48'h0));
    r = make_attach(3'd4, 48'h0000_1234_5678);
    r.req_type = REQ_UNUSED;
    send_req(r);
    send_req(make_alloc(3'd6, 31'd4096, 5'd0, 1'b0, 5'd0, 48'h0000_0800_0000, 1'b1));
    send_req(make_alloc(3'd7, 31'd100, 5'd0, 1'b0, 5'd0, 48'h0000_0C00_0000, 1'b1));
    send_req(make_alloc(3'd7, 31'd10, 5'd31, 1'b0, 5'd0, 48'h0000_0D00_0000, 1'b1));
    send_req(make_alloc(3'd5, 31'd131072, 5'd0, 1'b0, 5'd0, 48'h0000_0E00_0000, 1'b1));
    send_req(make_alloc(3'd5, 31'd1000, 5'd0, 1'b1, 5'd31, 48'h0000_0F00_0000, 1'b1));
    send_req(make_alloc(3'd3, 31'd48, 5'd4, 1'b1, 5'd4, 48'h0000_1000_0000, 1'b1));
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) send_req(random_request());
  endtask

  task automatic test_extent_size_saturation();
    set_extent_log2(5'd0);
    test_random_traffic(40);
    set_extent_log2(5'd31);
    test_random_traffic(40);
  endtask

  task automatic test_result_backpressure();
    hold_req <= ~hold_req;
    test_random_traffic(30);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      free_ptr[i] = '0;
      spare_ext[i] = '0;
      kind_of[i] = '0;
    end
    ext_log2_reg = EXT_LOG2_RST;
    send_idle_pct = 38;
    recv_idle_pct = 55;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_prime_batches();
    test_corner_cases();
    test_extent_size_saturation();
    set_extent_log2(EXT_LOG2_MIN);
    test_random_traffic(500);
    send_idle_pct = 55;
    recv_idle_pct = 38;
    set_extent_log2(EXT_LOG2_MAX);
    test_random_traffic(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_extent_log2(5'd20);
    test_result_backpressure();
    test_random_traffic(450);
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
